// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the checker in sst_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication with synchronous active-low reset disable
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// clocked implication checked in the next cycle
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sst_pkg.sv -----
// shared types, codes and sizes for the servo step test sequencer
// no dependencies
package sst_pkg;

  localparam int COUNT_BITS = 16;
  localparam int ANGLE_BITS = 14;
  localparam int ENC_BITS   = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;
  localparam int OUT_BITS   = 40;

  localparam logic [1:0] PH_FORWARD = 2'd0;
  localparam logic [1:0] PH_RETURN  = 2'd1;
  localparam logic [1:0] PH_COAST   = 2'd2;
  localparam logic [1:0] PH_IDLE    = 2'd3;

  localparam logic [IDX_BITS-1:0] REG_START_CW   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_TARGET     = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_RETURN_EN  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_RETURN_ANG = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SAMPLES    = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_INTERVAL   = 3'd5;

  localparam logic [COUNT_BITS-1:0] INTERVAL_RESET = COUNT_BITS'(500);

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic                         start_clockwise;
    logic signed [ANGLE_BITS-1:0] target_angle;
    logic                         return_enabled;
    logic signed [ANGLE_BITS-1:0] return_angle;
    count_t                       sample_count;
    count_t                       tick_interval;
  } cfg_t;

  typedef struct packed {
    logic [1:0] run_phase;
    count_t     tick_counter;
    count_t     samples_taken;
  } state_t;

  typedef struct packed {
    logic                       motor_on;
    logic                       motor_clockwise;
    logic                       sample_valid;
    logic signed [ENC_BITS-1:0] sample_value;
    count_t                     sample_index;
    logic [1:0]                 phase;
    logic                       done_res;
  } result_t;

endpackage

// ----- hw/rtl/sst_cfg_regs.sv -----
// configuration register file for the step test sequencer
// depends on sst_pkg
module sst_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sst_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [sst_pkg::CFG_BITS-1:0]     cfg_wdata,
  output sst_pkg::cfg_t                    cfg
);
  import sst_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CW:   cfg_nxt.start_clockwise = cfg_wdata[0];
        REG_TARGET:     cfg_nxt.target_angle    = signed'(cfg_wdata[ANGLE_BITS-1:0]);
        REG_RETURN_EN:  cfg_nxt.return_enabled  = cfg_wdata[0];
        REG_RETURN_ANG: cfg_nxt.return_angle    = signed'(cfg_wdata[ANGLE_BITS-1:0]);
        REG_SAMPLES:    cfg_nxt.sample_count    = cfg_wdata[COUNT_BITS-1:0];
        REG_INTERVAL:   cfg_nxt.tick_interval   = cfg_wdata[COUNT_BITS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_clockwise <= 1'b1;
      cfg_r.target_angle    <= '0;
      cfg_r.return_enabled  <= 1'b1;
      cfg_r.return_angle    <= '0;
      cfg_r.sample_count    <= COUNT_BITS'(1);
      cfg_r.tick_interval   <= INTERVAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/sst_step.sv -----
// next-state and result logic for one request of the step test sequencer
// depends on sst_pkg
module sst_step (
  input  sst_pkg::cfg_t                        cfg,
  input  sst_pkg::state_t                      state,
  input  logic                                 mode,
  input  logic signed [sst_pkg::ENC_BITS-1:0]  enc,
  output sst_pkg::state_t                      state_nxt,
  output sst_pkg::result_t                     res
);
  import sst_pkg::*;

  count_t                     ivl;
  count_t                     tc;
  count_t                     tk;
  logic [COUNT_BITS:0]        tc_inc;
  logic [1:0]                 ph;
  logic                       instant;
  logic                       sampled;
  logic                       cw;
  logic signed [ENC_BITS-1:0] tgt;
  logic signed [ENC_BITS-1:0] rtn;
  logic                       pass_tgt;
  logic                       pass_rtn;

  // thresholds sign-extended to encoder width
  assign tgt = ENC_BITS'(cfg.target_angle);
  assign rtn = ENC_BITS'(cfg.return_angle);
  assign cw  = cfg.start_clockwise;
  assign pass_tgt = cw ? (enc >= tgt) : (enc <= tgt);
  assign pass_rtn = cw ? (enc <= rtn) : (enc >= rtn);

  always_comb begin
    ivl     = (cfg.tick_interval == '0) ? COUNT_BITS'(1) : cfg.tick_interval;
    ph      = state.run_phase;
    tc      = state.tick_counter;
    tk      = state.samples_taken;
    instant = 1'b0;
    sampled = 1'b0;
    tc_inc  = {1'b0, tc} + (COUNT_BITS+1)'(1);

    if (mode) begin
      ph      = PH_FORWARD;
      tk      = '0;
      tc      = '0;
      instant = 1'b1;
    end else if (ph != PH_IDLE) begin
      if (tk >= cfg.sample_count) begin
        // all samples in: count up to the interval and stay there
        if (tc < ivl) tc = tc_inc[COUNT_BITS-1:0];
        instant = (tc >= ivl);
      end else if (tc_inc >= {1'b0, ivl}) begin
        tc      = '0;
        instant = 1'b1;
      end else begin
        tc = tc_inc[COUNT_BITS-1:0];
      end
    end

    res.sample_index = '0;
    if (instant) begin
      // both thresholds may be passed on the same request
      if (ph == PH_FORWARD && pass_tgt) ph = cfg.return_enabled ? PH_RETURN : PH_COAST;
      if (ph == PH_RETURN && pass_rtn) ph = PH_COAST;
      if (tk < cfg.sample_count) begin
        sampled          = 1'b1;
        res.sample_index = tk;
        tk               = tk + COUNT_BITS'(1);
        tc               = '0;
      end
    end

    state_nxt.run_phase     = ph;
    state_nxt.tick_counter  = tc;
    state_nxt.samples_taken = tk;

    res.motor_on        = (ph == PH_FORWARD) || (ph == PH_RETURN);
    res.motor_clockwise = ((ph == PH_FORWARD) && cw) || ((ph == PH_RETURN) && !cw);
    res.sample_valid    = sampled;
    res.sample_value    = sampled ? enc : '0;
    res.phase           = ph;
    res.done_res        = (ph == PH_COAST) && (tk >= cfg.sample_count);
  end

endmodule

// ----- hw/rtl/servo_step_test_sequencer_core.sv -----
// top level of the servo step test sequencer: streaming ports, state and pipeline registers
// depends on sst_pkg, sst_cfg_regs and sst_step
//
// Each input request is one timer tick (in_tuser low) or the start of a new run
// (in_tuser high) together with the current encoder count. Every request yields
// exactly one result: the motor command (on, direction), the run phase, a done
// flag and, at sample instants, the encoder count with its index in the run
// (out_tuser high). A start drives the motor at full power toward target_angle,
// optionally back past return_angle, then coasts. The block takes one request
// per clock while out_tready does not stall it; a taken request moves into the
// input register and then into the result register, which offers it (one input
// register, one result register). The run state is updated in the single
// combinational step between those registers, so consecutive requests never
// wait on each other. out_tready low stalls the result register and, through
// it, the input register; in_tready then falls only when both are full.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata while no
// request is in flight; the block does not enforce this. Reset values are
// clockwise, angles zero, return enabled, one sample and an interval of 500 ticks.
module servo_step_test_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [sst_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [sst_pkg::CFG_BITS-1:0]    cfg_wdata,
  // input request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sst_pkg::ENC_BITS-1:0]    in_tdata,   // [15:0] encoder_count
  input  logic                            in_tuser,   // [0] mode
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] motor_on, [1] motor_clockwise, [17:2] sample_value, [33:18] sample_index,
  // [35:34] phase, [36] done_res, [39:37] zero
  output logic [sst_pkg::OUT_BITS-1:0]    out_tdata,
  output logic                            out_tuser   // [0] sample_valid
);
  import sst_pkg::*;

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  result_t res;
  result_t res_r;

  // input register
  logic                       s1_valid_r;
  logic                       s1_mode_r;
  logic signed [ENC_BITS-1:0] s1_enc_r;
  logic                       out_valid_r;
  logic                       advance;

  sst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sst_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .mode      (s1_mode_r),
    .enc       (s1_enc_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  // result register moves when empty or being taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tuser;
      s1_enc_r  <= signed'(in_tdata);
    end
  end

  // run state advances exactly when a request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r           <= 1'b0;
      state_r.run_phase     <= PH_IDLE;
      state_r.tick_counter  <= '0;
      state_r.samples_taken <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.sample_valid;
  assign out_tdata  = {3'b000, res_r.done_res, res_r.phase, res_r.sample_index,
                       res_r.sample_value, res_r.motor_clockwise, res_r.motor_on};

endmodule

// ----- hw/rtl/sst_checker.sv -----
// port-level checks on the result stream of the step test sequencer, bound to the top level
// depends on sst_pkg and assert_macros.svh
`include "assert_macros.svh"

module sst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [sst_pkg::OUT_BITS-1:0]  out_tdata,
  input logic                          out_tuser
);
  import sst_pkg::*;

  logic       motor_on;
  logic       motor_cw;
  logic [1:0] phase;
  logic       done;

  assign motor_on = out_tdata[0];
  assign motor_cw = out_tdata[1];
  assign phase    = out_tdata[35:34];
  assign done     = out_tdata[36];

  // stalled result holds
  `SST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // no sample means zero value and index
  `SST_ASSERT_IMP(a_no_sample_zero, clk, rst_n, out_tvalid && !out_tuser,
    out_tdata[33:2] == 32'd0, "sample fields nonzero without a sample")

  // motor is on exactly in the powered phases
  `SST_ASSERT_IMP(a_motor_phase, clk, rst_n, out_tvalid,
    motor_on == (phase == PH_FORWARD || phase == PH_RETURN), "motor state disagrees with phase")

  // direction only reported while driven
  `SST_ASSERT_IMP(a_dir_off, clk, rst_n, out_tvalid && !motor_on,
    !motor_cw, "direction set while motor off")

  // done only while coasting
  `SST_ASSERT_IMP(a_done_coast, clk, rst_n, out_tvalid && done,
    phase == PH_COAST, "done outside coasting phase")

endmodule

bind servo_step_test_sequencer_core sst_checker u_sst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/servo_step_test_sequencer_core_test.sv -----
// self-checking testbench for servo_step_test_sequencer_core: drives tick and start requests,
// predicts every result in a cycle model of the run sequencer and checks the result stream
// depends on sst_pkg and servo_step_test_sequencer_core
`timescale 1ns / 100ps

module servo_step_test_sequencer_core_test;
  import sst_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // length of the long receiver hold-off that fills the block up
  localparam int HOLD_CYCLES = 300;

  // one input request: start flag and encoder count
  typedef struct packed {
    logic                start;
    logic [ENC_BITS-1:0] enc;
  } tick_req_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [IDX_BITS-1:0] cfg_index  = '0;
  logic [CFG_BITS-1:0] cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [ENC_BITS-1:0] in_tdata   = '0;   // [15:0] encoder_count
  logic                in_tuser   = 1'b0; // [0] mode
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [0] motor_on, [1] motor_clockwise, [17:2] sample_value, [33:18] sample_index,
  // [35:34] phase, [36] done_res, [39:37] zero
  logic [OUT_BITS-1:0] out_tdata;
  logic                out_tuser;         // [0] sample_valid

  // requests waiting for the driver, results waiting for the block
  tick_req_t tick_feed[$];
  result_t   pending_results[$];

  // sequencer model: its own copy of the registers and the run state
  cfg_t       srv_cfg;
  logic [1:0] run_ph       = PH_IDLE;
  count_t     tick_count   = '0;
  count_t     samples_done = '0;

  // traffic shaping, set by the sequence in the initial block
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;
  int hold_left      = 0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  servo_step_test_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // sequencer model
  // ---------------------------------------------------------------------------

  // clockwise drive passes at or above the threshold, counterclockwise at or below
  function automatic bit crossed(input bit cw, input int enc, input int thr);
    return cw ? (enc >= thr) : (enc <= thr);
  endfunction

  // phase check at an instant: forward and return may both be passed on one request
  function automatic void advance_phase(input int enc);
    bit cw;
    cw = srv_cfg.start_clockwise;
    if (run_ph == PH_FORWARD && crossed(cw, enc, int'($signed(srv_cfg.target_angle))))
      run_ph = srv_cfg.return_enabled ? PH_RETURN : PH_COAST;
    if (run_ph == PH_RETURN && crossed(!cw, enc, int'($signed(srv_cfg.return_angle))))
      run_ph = PH_COAST;
  endfunction

  // apply one accepted request to the run state and return the result it yields
  function automatic result_t step_servo(input logic start, input logic signed [15:0] enc);
    result_t r;
    int      total;
    int      ivl;
    int      tick;
    bit      instant;
    bit      sampled;
    count_t  idx;
    total   = int'(srv_cfg.sample_count);
    ivl     = int'(srv_cfg.tick_interval);
    tick    = int'(tick_count);
    instant = 1'b0;
    sampled = 1'b0;
    idx     = '0;
    // an interval of zero counts as one tick
    if (ivl == 0)
      ivl = 1;

    if (start) begin
      // a start also restarts a run in progress
      run_ph       = PH_FORWARD;
      samples_done = '0;
      tick         = 0;
      instant      = 1'b1;
    end else if (run_ph != PH_IDLE) begin
      if (int'(samples_done) >= total) begin
        // all samples taken: counter parks at the interval, then every tick checks
        if (tick < ivl)
          tick++;
        instant = (tick >= ivl);
      end else begin
        tick++;
        if (tick >= ivl) begin
          tick    = 0;
          instant = 1'b1;
        end
      end
    end

    if (instant) begin
      advance_phase(int'(enc));
      if (int'(samples_done) < total) begin
        sampled      = 1'b1;
        idx          = samples_done;
        samples_done = samples_done + count_t'(1);
        tick         = 0;
      end
    end
    tick_count = count_t'(tick);

    r.motor_on        = (run_ph == PH_FORWARD) || (run_ph == PH_RETURN);
    r.motor_clockwise = (run_ph == PH_FORWARD) ? srv_cfg.start_clockwise :
                        (run_ph == PH_RETURN)  ? !srv_cfg.start_clockwise : 1'b0;
    r.sample_valid    = sampled;
    r.sample_value    = sampled ? enc : '0;
    r.sample_index    = idx;
    r.phase           = run_ph;
    r.done_res        = (run_ph == PH_COAST) && (int'(samples_done) >= total);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    tick_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // request taken at this edge: predict with the values the block saw
      if (in_tvalid && in_tready)
        pending_results.push_back(step_servo(in_tuser, $signed(in_tdata)));
      // a request that is still waiting stays on the bus untouched
      if (!in_tvalid || in_tready) begin
        if (tick_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.start;
          in_tdata  <= nxt.enc;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results against the oldest prediction, drives backpressure
  // ---------------------------------------------------------------------------
  task automatic flag_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.motor_on        = out_tdata[0];
        got.motor_clockwise = out_tdata[1];
        got.sample_value    = out_tdata[17:2];
        got.sample_index    = out_tdata[33:18];
        got.phase           = out_tdata[35:34];
        got.done_res        = out_tdata[36];
        got.sample_valid    = out_tuser;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h/%b",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.motor_on !== want.motor_on)
            flag_field("motor_on", 16'(want.motor_on), 16'(got.motor_on));
          if (got.motor_clockwise !== want.motor_clockwise)
            flag_field("motor_clockwise", 16'(want.motor_clockwise),
                       16'(got.motor_clockwise));
          if (got.sample_valid !== want.sample_valid)
            flag_field("sample_valid", 16'(want.sample_valid), 16'(got.sample_valid));
          if (got.sample_value !== want.sample_value)
            flag_field("sample_value", want.sample_value, got.sample_value);
          if (got.sample_index !== want.sample_index)
            flag_field("sample_index", want.sample_index, got.sample_index);
          if (got.phase !== want.phase)
            flag_field("phase", 16'(want.phase), 16'(got.phase));
          if (got.done_res !== want.done_res)
            flag_field("done_res", 16'(want.done_res), 16'(got.done_res));
          if (out_tdata[39:37] !== 3'b000)
            flag_field("pad bits", 16'h0, 16'(out_tdata[39:37]));
        end
      end
      // long hold-off asked for by the sequence, counted here
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no handshake happens for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one register write; the model copy follows at the same moment
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_START_CW:   srv_cfg.start_clockwise = val[0];
      REG_TARGET:     srv_cfg.target_angle    = val[ANGLE_BITS-1:0];
      REG_RETURN_EN:  srv_cfg.return_enabled  = val[0];
      REG_RETURN_ANG: srv_cfg.return_angle    = val[ANGLE_BITS-1:0];
      REG_SAMPLES:    srv_cfg.sample_count    = val;
      REG_INTERVAL:   srv_cfg.tick_interval   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input bit cw, input int tgt, input bit ren, input int ret,
                            input int cnt, input int ivl);
    write_reg(REG_START_CW, CFG_BITS'(cw));
    write_reg(REG_TARGET, CFG_BITS'(tgt) & 16'h3fff);
    write_reg(REG_RETURN_EN, CFG_BITS'(ren));
    write_reg(REG_RETURN_ANG, CFG_BITS'(ret) & 16'h3fff);
    write_reg(REG_SAMPLES, CFG_BITS'(cnt));
    write_reg(REG_INTERVAL, CFG_BITS'(ivl));
  endtask

  // queue one request, encoder count clamped to its 16-bit range
  task automatic queue_req(input bit start, input int enc);
    tick_req_t r;
    if (enc > 32767)
      enc = 32767;
    if (enc < -32768)
      enc = -32768;
    r.start = start;
    r.enc   = ENC_BITS'(enc);
    tick_feed.push_back(r);
  endtask

  // mostly inside the usable span, sometimes the ends of the 14-bit field
  function automatic int pick_angle();
    case ($urandom_range(9))
      0:       return -8192;
      1:       return 8191;
      default: return int'($urandom_range(8192)) - 4096;
    endcase
  endfunction

  // a plausible run: start short of the target, sweep past it, then sweep back;
  // some counts are replaced by noise and a few ticks are restarts
  task automatic add_run(input int n_ticks);
    int dir;
    int pos;
    int stride;
    int enc_v;
    dir    = srv_cfg.start_clockwise ? 1 : -1;
    stride = $urandom_range(1, 300);
    pos    = int'($signed(srv_cfg.target_angle)) - dir * stride * int'($urandom_range(12));
    queue_req(1'b1, pos);
    for (int i = 0; i < n_ticks; i++) begin
      if (i < n_ticks / 2)
        pos += dir * stride;
      else
        pos -= dir * stride;
      enc_v = pos;
      if ($urandom_range(9) == 0)
        enc_v = int'($urandom_range(65535)) - 32768;
      queue_req($urandom_range(31) == 0, enc_v);
    end
  endtask

  task automatic fill_runs(input int budget);
    int used;
    int n;
    used = 0;
    while (used < budget) begin
      n = $urandom_range(4, 40);
      add_run(n);
      used += n + 1;
    end
  endtask

  // wait until every queued request is taken and every result is back
  task automatic drain_results();
    while (tick_feed.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
    // two-stage pipeline, let it go quiet before moving on
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  tgt;
    int  ret;
    int  cnt;
    int  ivl;
    bit  cw;
    srv_cfg = '{start_clockwise: 1'b1, target_angle: '0, return_enabled: 1'b1,
                return_angle: '0, sample_count: count_t'(1), tick_interval: INTERVAL_RESET};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: ticks while idle change nothing; with both angles at zero a
    // start at count zero passes forward and return on the same request
    queue_req(1'b0, -32768);
    queue_req(1'b0, 32767);
    queue_req(1'b1, 0);
    queue_req(1'b0, 5);
    drain_results();

    // counterclockwise run, three samples two ticks apart
    set_config(1'b0, -100, 1'b1, 100, 3, 2);
    queue_req(1'b1, 0);
    queue_req(1'b0, -50);
    queue_req(1'b0, -150);      // passes target, powered return begins
    queue_req(1'b0, 50);
    queue_req(1'b0, 150);       // passes return angle, coasting and full
    queue_req(1'b0, 0);
    queue_req(1'b0, 0);         // check instant after the last sample
    queue_req(1'b1, -32768);    // restart during a run
    queue_req(1'b0, 32767);
    queue_req(1'b0, 32767);
    drain_results();

    // no samples at all, zero interval, no powered return, extreme angles
    set_config(1'b1, 8191, 1'b0, -8192, 0, 0);
    queue_req(1'b1, 8190);
    queue_req(1'b0, 8191);      // every tick checks, goes straight to coasting
    queue_req(1'b0, -1);
    drain_results();

    // random runs under several settings and traffic patterns
    for (int ph = 0; ph < 8; ph++) begin
      cw  = 1'($urandom_range(1));
      tgt = pick_angle();
      // return angle usually on the way back from the target
      if ($urandom_range(9) < 7)
        ret = tgt - (cw ? 1 : -1) * int'($urandom_range(2000));
      else
        ret = pick_angle();
      cnt = $urandom_range(1, 16);
      ivl = $urandom_range(1, (ph == 3) ? 12 : 4);
      if (ph == 6) begin
        // largest counts: only the start instant ever samples
        cnt = 65535;
        ivl = 65535;
      end else if (ph == 7) begin
        cnt = $urandom_range(1);
        ivl = 0;
      end
      set_config(cw, tgt, 1'($urandom_range(1)), ret, cnt, ivl);

      @(negedge clk);
      case (ph)
        1, 5:    begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2, 6:    begin send_idle_pct = 0;  recv_stall_pct = 63; end
        3, 7:    begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase

      if (ph == 4) begin
        // receiver holds off while the sender keeps offering: the block fills up
        hold_pending = 1'b1;
      end
      if (ph == 5) begin
        // sender pauses mid-phase until everything in flight has come back
        fill_runs(40);
        drain_results();
        fill_runs(45);
      end else begin
        fill_runs(85);
      end
      drain_results();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results still expected, actual none", $time,
               pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
